// File: design/gbbc_pkg.sv
`default_nettype none

package gbbc_pkg;

	localparam logic [1:0] CMD_BASIS  = 2'd0;
	localparam logic [1:0] CMD_CONT   = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};
	localparam logic signed [63:0] ROUND_HALF = 64'sd8388608;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? ACC_MIN : ACC_MAX;
		end
		return s;
	endfunction

	// Q.40 accumulator to Q16.16: add half, floor shift by 24, clamp to 32 bits
	function automatic logic signed [31:0] round_sat(input logic signed [63:0] acc);
		logic signed [63:0] x;
		logic        [39:0] r;
		logic signed [31:0] y;
		x = sat_add64(acc, ROUND_HALF);
		r = x[63:24];
		if (!r[39] && (|r[38:31])) begin
			y = {1'b0, {31{1'b1}}};
		end else if (r[39] && !(&r[38:31])) begin
			y = {1'b1, {31{1'b0}}};
		end else begin
			y = r[31:0];
		end
		return y;
	endfunction

endpackage

`default_nettype wire

// File: design/gbbc_ram.sv
`default_nettype none

module gbbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/gram_blend_boundary_continuation.sv
`default_nettype none

// Gram-blend boundary continuation. Load transactions (tuser = basis / continuation)
// write the D x D basis Q and the R x D continuation matrix A into two RAMs;
// every matrix entry must be loaded before a column uses it. Sample transactions
// bring the first D samples of a column. On the D-th sample the input stalls while
// one multiply-accumulate unit, fed by one coefficient read per cycle while the output
// is not back-pressured, computes p = Q^T * reversed samples, drains its pipeline and
// then computes c = A * p. Loads and the first D-1 samples are accepted while the
// block is idle. Results leave as R+1 transactions: c in reverse row order, then
// the first sample with tlast set.
module gram_blend_boundary_continuation
	import gbbc_pkg::*;
#(
	parameter int MATCH_POINTS = 5,
	parameter int CONT_ROWS    = 31
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // row[5:0], col[9:6], value[41:10]
	input  wire logic [1:0]             s_axis_tuser,  // cmd[1:0]
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // result[31:0], out_row[37:32]
	output logic                        m_axis_tlast
);

	localparam int D     = MATCH_POINTS;
	localparam int R     = CONT_ROWS;
	localparam int KW    = $clog2(D);
	localparam int IW    = $clog2((R > D) ? R : D);
	localparam int BA_N  = D * D;
	localparam int CA_N  = R * D;
	localparam int BA_W  = $clog2(BA_N);
	localparam int CA_W  = $clog2(CA_N);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PROJ  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_CONT  = 5'b01000,
		S_TAIL  = 5'b10000
	} state_t;

	state_t state_q;

	logic [5:0]         in_row;
	logic [3:0]         in_col;
	logic signed [31:0] in_value;
	logic               in_acc;

	logic [KW-1:0] cnt_q;
	logic [IW-1:0] i_q;
	logic [KW-1:0] k_q;
	logic [5:0]    out_cnt_q;

	logic signed [31:0] samp_q [D];
	logic signed [31:0] proj_q [D];

	logic en;
	logic issue;
	logic pipe_empty;
	logic k_end;

	logic               ba_we;
	logic [BA_W-1:0]    ba_waddr;
	logic [BA_W-1:0]    ba_raddr;
	logic [31:0]        ba_rdata;
	logic               ca_we;
	logic [CA_W-1:0]    ca_waddr;
	logic [CA_W-1:0]    ca_raddr;
	logic [31:0]        ca_rdata;

	logic               v_s1, f_s1, lt_s1, c_s1;
	logic [KW-1:0]      idx_s1;
	logic signed [31:0] data_s1;
	logic               v_s2, f_s2, lt_s2, c_s2;
	logic [KW-1:0]      idx_s2;
	logic signed [63:0] prod_s2;
	logic               v_s3, c_s3;
	logic [KW-1:0]      idx_s3;
	logic signed [63:0] acc_q;
	logic               v_s4, c_s4;
	logic [KW-1:0]      idx_s4;
	logic signed [31:0] rnd_s4;

	logic               out_valid_q;
	logic signed [31:0] out_result_q;
	logic [5:0]         out_row_q;
	logic               out_last_q;

	logic               push_cont;
	logic               push_tail;
	logic signed [31:0] coef;
	logic signed [31:0] operand;

	assign in_row   = s_axis_tdata[5:0];
	assign in_col   = s_axis_tdata[9:6];
	assign in_value = s_axis_tdata[41:10];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	assign en         = !out_valid_q || m_axis_tready;
	assign issue      = en && ((state_q == S_PROJ) || (state_q == S_CONT));
	assign pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign k_end      = (k_q == KW'(D - 1));
	assign push_cont  = en && v_s4 && c_s4;
	assign push_tail  = en && (state_q == S_TAIL) && pipe_empty;

	assign ba_we    = in_acc && (s_axis_tuser == CMD_BASIS) &&
		(in_row < 6'(D)) && ({2'b00, in_col} < 6'(D));
	assign ca_we    = in_acc && (s_axis_tuser == CMD_CONT) &&
		(in_row < 6'(R)) && ({2'b00, in_col} < 6'(D));
	assign ba_waddr = BA_W'(int'(in_row) * D + int'(in_col));
	assign ca_waddr = CA_W'(int'(in_row) * D + int'(in_col));
	assign ba_raddr = BA_W'(int'(k_q) * D + int'(i_q));
	assign ca_raddr = CA_W'(int'(i_q) * D + int'(k_q));

	gbbc_ram #(.WIDTH(32), .DEPTH(BA_N)) u_basis_ram (
		.clk   (clk),
		.we    (ba_we),
		.waddr (ba_waddr),
		.wdata (in_value),
		.re    (en),
		.raddr (ba_raddr),
		.rdata (ba_rdata)
	);

	gbbc_ram #(.WIDTH(32), .DEPTH(CA_N)) u_cont_ram (
		.clk   (clk),
		.we    (ca_we),
		.waddr (ca_waddr),
		.wdata (in_value),
		.re    (en),
		.raddr (ca_raddr),
		.rdata (ca_rdata)
	);

	assign operand = (state_q == S_CONT) ? proj_q[k_q] : samp_q[KW'(D - 1) - k_q];
	assign coef    = c_s1 ? ca_rdata : ba_rdata;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			i_q       <= '0;
			k_q       <= '0;
			out_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && s_axis_tuser == CMD_SAMPLE) begin
						if (cnt_q == KW'(D - 1)) begin
							cnt_q     <= '0;
							i_q       <= '0;
							k_q       <= '0;
							out_cnt_q <= '0;
							state_q   <= S_PROJ;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_PROJ: begin
					if (issue) begin
						if (k_end) begin
							k_q <= '0;
							if (i_q == IW'(D - 1)) begin
								state_q <= S_DRAIN;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_DRAIN: begin
					if (pipe_empty) begin
						i_q     <= IW'(R - 1);
						k_q     <= '0;
						state_q <= S_CONT;
					end
				end
				S_CONT: begin
					if (issue) begin
						if (k_end) begin
							k_q <= '0;
							if (i_q == '0) begin
								state_q <= S_TAIL;
							end else begin
								i_q <= i_q - 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_TAIL: begin
					if (push_tail) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (push_cont) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end
		end
	end

	// MAC pipeline valids and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2 && lt_s2;
				v_s4 <= v_s3;
			end
			if (push_cont || push_tail) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == CMD_SAMPLE) begin
			samp_q[cnt_q] <= in_value;
		end
		if (en) begin
			f_s1    <= (k_q == '0);
			lt_s1   <= k_end;
			c_s1    <= (state_q == S_CONT);
			idx_s1  <= i_q[KW-1:0];
			data_s1 <= operand;

			f_s2    <= f_s1;
			lt_s2   <= lt_s1;
			c_s2    <= c_s1;
			idx_s2  <= idx_s1;
			prod_s2 <= coef * data_s1;

			if (v_s2) begin
				acc_q <= f_s2 ? prod_s2 : sat_add64(acc_q, prod_s2);
			end
			c_s3   <= c_s2;
			idx_s3 <= idx_s2;

			rnd_s4 <= round_sat(acc_q);
			c_s4   <= c_s3;
			idx_s4 <= idx_s3;

			if (v_s4 && !c_s4) begin
				proj_q[idx_s4] <= rnd_s4;
			end
		end
		if (push_cont) begin
			out_result_q <= rnd_s4;
			out_row_q    <= out_cnt_q;
			out_last_q   <= 1'b0;
		end else if (push_tail) begin
			out_result_q <= samp_q[0];
			out_row_q    <= out_cnt_q;
			out_last_q   <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_row_q, out_result_q};
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: design/gbbc_checker.sv
`default_nettype none

module gbbc_checker
	import gbbc_pkg::*;
#(
	parameter int CONT_ROWS = 31
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input wire logic [1:0]             s_axis_tuser,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tlast
);

	// the boundary sample closes the column at row CONT_ROWS and nowhere else
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[37:32] == 6'(CONT_ROWS))))
		else $error("tlast does not match the final row");

	// input stays stalled while continuation results of a column are pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
		else $error("input accepted during a column's continuation");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("output transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("output payload changed while stalled");

endmodule

bind gram_blend_boundary_continuation gbbc_checker #(.CONT_ROWS(CONT_ROWS)) u_gbbc_checker (.*);

`default_nettype wire
